// File: hw/rtl/hss_pkg.sv
`default_nettype none
package hss_pkg;

	localparam int RAW_W      = 20;
	localparam int PERIOD_W   = 24;
	localparam int TICK_W     = 16;
	localparam int READ_W     = 48;
	localparam int SEND_W     = 24;
	localparam int TEMP_W     = 15;
	localparam int HUM_W      = 14;
	localparam int STATUS_BIT = 47;

	localparam logic [1:0] CMD_TICK    = 2'd0;
	localparam logic [1:0] CMD_RUN     = 2'd1;
	localparam logic [1:0] CMD_REQ     = 2'd2;
	localparam logic [1:0] CMD_RESTART = 2'd3;

	localparam logic [1:0] CNT_NONE  = 2'd0;
	localparam logic [1:0] CNT_RESET = 2'd1;
	localparam logic [1:0] CNT_CMD   = 2'd3;

	localparam logic [SEND_W-1:0] SEND_NONE  = 24'h000000;
	localparam logic [SEND_W-1:0] SEND_RESET = 24'hBA0000;
	localparam logic [SEND_W-1:0] SEND_INIT  = 24'hE10800;
	localparam logic [SEND_W-1:0] SEND_MEAS  = 24'hAC3300;

	localparam logic CFG_IDX_MODE   = 1'b0;
	localparam logic CFG_IDX_PERIOD = 1'b1;

	localparam logic                MODE_MANUAL  = 1'b0;
	localparam logic                MODE_AUTO    = 1'b1;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd1000;

	localparam int WAIT_SHORT_MS = 25;
	localparam int MEAS_MS       = 80;

	localparam logic [14:0] TEMP_SCALE  = 15'd20000;
	localparam logic [14:0] TEMP_OFFSET = 15'd5000;
	localparam logic [13:0] HUM_SCALE   = 14'd10000;

	typedef enum logic [1:0] {
		PH_WAKE  = 2'd0,
		PH_RESET = 2'd1,
		PH_INIT  = 2'd2,
		PH_WORK  = 2'd3
	} phase_t;

	typedef struct packed {
		logic                work_mode;
		logic [PERIOD_W-1:0] meas_period;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        send_count;
		logic [SEND_W-1:0] send_bytes;
		logic              read_done;
		logic              data_valid;
	} ctrl_res_t;

endpackage
`default_nettype wire

// File: hw/rtl/hss_if.sv
`default_nettype none
interface hss_in_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 cmd;
	logic [hss_pkg::TICK_W-1:0] tick_ms;
	logic [hss_pkg::READ_W-1:0] read_data;

	modport source (output valid, cmd, tick_ms, read_data, input ready);
	modport sink (input valid, cmd, tick_ms, read_data, output ready);
endinterface

interface hss_out_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        send_count;
	logic [hss_pkg::SEND_W-1:0]        send_bytes;
	logic                              read_done;
	logic                              data_valid;
	logic signed [hss_pkg::TEMP_W-1:0] temperature_centi;
	logic [hss_pkg::HUM_W-1:0]         humidity_centi;

	modport source (output valid, send_count, send_bytes, read_done, data_valid,
		temperature_centi, humidity_centi, input ready);
	modport sink (input valid, send_count, send_bytes, read_done, data_valid,
		temperature_centi, humidity_centi, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/humidity_sensor_sequencer_unit.sv
`default_nettype none
// Sequencer for a temperature and humidity sensor: ticks, run polls, manual
// requests and sequence resets come in, and every input transfer yields exactly
// one result transfer holding the command bytes to send now, the read flags and
// the converted readings in hundredths. One item is taken every clock cycle while
// the result side is not stalled; each input passes through the input register
// and then the result register, and the timing logic between the two decides the
// next state and the result together. A stalled result holds the input side back
// only once both registers are full.
module humidity_sensor_sequencer_unit #(
	parameter int TIMER_BITS = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic                         cfg_index,
	input  wire logic [hss_pkg::PERIOD_W-1:0] cfg_data,
	hss_in_if.sink                            items,
	hss_out_if.source                         results
);
	import hss_pkg::*;

	cfg_t               cfg_q;
	logic               vld_s1;
	logic [1:0]         cmd_s1;
	logic [TICK_W-1:0]  tick_s1;
	logic [READ_W-1:0]  rd_s1;
	logic               vld_s2;
	ctrl_res_t          res_s2;
	logic signed [TEMP_W-1:0] temp_s2;
	logic [HUM_W-1:0]   hum_s2;
	logic               adv;
	logic               fire;
	ctrl_res_t          res;
	logic signed [TEMP_W-1:0] temp;
	logic [HUM_W-1:0]   hum;

	assign adv         = !vld_s2 || results.ready;
	assign fire        = vld_s1 && adv;
	assign items.ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.work_mode   <= MODE_MANUAL;
			cfg_q.meas_period <= PERIOD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IDX_MODE:   cfg_q.work_mode <= cfg_data[0];
				CFG_IDX_PERIOD: cfg_q.meas_period <= cfg_data;
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	hss_ctrl #(
		.TIMER_BITS(TIMER_BITS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.cmd    (cmd_s1),
		.tick_ms(tick_s1),
		.busy   (rd_s1[STATUS_BIT]),
		.cfg    (cfg_q),
		.res    (res)
	);

	hss_conv u_conv (
		.raw_t(rd_s1[RAW_W-1:0]),
		.raw_h(rd_s1[2*RAW_W-1:RAW_W]),
		.temp (temp),
		.hum  (hum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (items.ready) begin
				vld_s1 <= items.valid;
			end
			if (adv) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			cmd_s1  <= items.cmd;
			tick_s1 <= items.tick_ms;
			rd_s1   <= items.read_data;
		end
		if (fire) begin
			res_s2  <= res;
			temp_s2 <= res.data_valid ? temp : '0;
			hum_s2  <= res.data_valid ? hum : '0;
		end
	end

	assign results.valid             = vld_s2;
	assign results.send_count        = res_s2.send_count;
	assign results.send_bytes        = res_s2.send_bytes;
	assign results.read_done         = res_s2.read_done;
	assign results.data_valid        = res_s2.data_valid;
	assign results.temperature_centi = temp_s2;
	assign results.humidity_centi    = hum_s2;
endmodule
`default_nettype wire

// File: hw/rtl/hss_conv.sv
`default_nettype none
module hss_conv (
	input  wire logic [hss_pkg::RAW_W-1:0]         raw_t,
	input  wire logic [hss_pkg::RAW_W-1:0]         raw_h,
	output logic signed [hss_pkg::TEMP_W-1:0]      temp,
	output logic [hss_pkg::HUM_W-1:0]              hum
);
	import hss_pkg::*;

	logic [RAW_W+15-1:0] q_t;
	logic [RAW_W+14-1:0] q_h;
	logic [TEMP_W-1:0]   fl;
	logic                frac;
	logic [TEMP_W-1:0]   ce;

	assign q_t  = (RAW_W+15)'(raw_t) * (RAW_W+15)'(TEMP_SCALE);
	assign q_h  = (RAW_W+14)'(raw_h) * (RAW_W+14)'(HUM_SCALE);
	assign fl   = q_t[RAW_W+15-1:RAW_W];
	assign frac = |q_t[RAW_W-1:0];

	// below the offset the result rounds toward zero, so take the ceiling
	assign ce   = fl + TEMP_W'((fl < TEMP_OFFSET) && frac);
	assign temp = signed'(ce - TEMP_OFFSET);
	assign hum  = q_h[RAW_W+14-1:RAW_W];
endmodule
`default_nettype wire

// File: hw/rtl/hss_ctrl.sv
`default_nettype none
module hss_ctrl #(
	parameter int TIMER_BITS = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       fire,
	input  wire logic [1:0]                 cmd,
	input  wire logic [hss_pkg::TICK_W-1:0] tick_ms,
	input  wire logic                       busy,
	input  wire hss_pkg::cfg_t              cfg,
	output hss_pkg::ctrl_res_t              res
);
	import hss_pkg::*;

	localparam int CW = (TIMER_BITS > PERIOD_W) ? TIMER_BITS : PERIOD_W;

	phase_t                phase_q, phase_n;
	logic                  pending_q, pending_n;
	logic [TIMER_BITS-1:0] elapsed_q, elapsed_n;
	logic [TIMER_BITS:0]   sum;
	logic [PERIOD_W-1:0]   per;
	logic                  short_done;
	logic                  meas_done;
	logic                  period_done;
	logic                  manual_req;

	assign sum         = {1'b0, elapsed_q} + (TIMER_BITS+1)'(tick_ms);
	assign per         = (cfg.meas_period < PERIOD_W'(MEAS_MS)) ? PERIOD_W'(MEAS_MS) :
		cfg.meas_period;
	assign short_done  = elapsed_q >= TIMER_BITS'(WAIT_SHORT_MS);
	assign meas_done   = elapsed_q >= TIMER_BITS'(MEAS_MS);
	assign period_done = CW'(elapsed_q) >= CW'(per);
	assign manual_req  = (cfg.work_mode == MODE_MANUAL) && !pending_q;

	always_comb begin
		phase_n   = phase_q;
		pending_n = pending_q;
		elapsed_n = elapsed_q;
		case (cmd)
			CMD_TICK: begin
				elapsed_n = sum[TIMER_BITS] ? '1 : sum[TIMER_BITS-1:0];
			end
			CMD_REQ: begin
				if (manual_req) begin
					elapsed_n = '0;
					pending_n = 1'b1;
				end
			end
			CMD_RESTART: begin
				pending_n = 1'b0;
				elapsed_n = '0;
				phase_n   = PH_RESET;
			end
			default: begin
				case (phase_q)
					PH_WAKE, PH_RESET: begin
						if (pending_q) begin
							if (short_done) begin
								pending_n = 1'b0;
								phase_n   = (phase_q == PH_WAKE) ? PH_RESET : PH_INIT;
							end
						end else begin
							elapsed_n = '0;
							pending_n = 1'b1;
						end
					end
					PH_INIT: begin
						if (pending_q) begin
							if (short_done) begin
								phase_n   = PH_WORK;
								pending_n = 1'b0;
								if (cfg.work_mode == MODE_AUTO) begin
									elapsed_n = '0;
									pending_n = 1'b1;
								end
							end
						end else begin
							elapsed_n = '0;
							pending_n = 1'b1;
						end
					end
					default: begin
						if (pending_q) begin
							if (meas_done) begin
								pending_n = 1'b0;
							end
						end else if (cfg.work_mode == MODE_AUTO && period_done) begin
							elapsed_n = '0;
							pending_n = 1'b1;
						end
					end
				endcase
			end
		endcase
	end

	always_comb begin
		res            = '0;
		res.send_count = CNT_NONE;
		res.send_bytes = SEND_NONE;
		case (cmd)
			CMD_REQ: begin
				if (manual_req) begin
					res.send_count = CNT_CMD;
					res.send_bytes = SEND_MEAS;
				end
			end
			CMD_RUN: begin
				case (phase_q)
					PH_RESET: begin
						if (!pending_q) begin
							res.send_count = CNT_RESET;
							res.send_bytes = SEND_RESET;
						end
					end
					PH_INIT: begin
						if (!pending_q) begin
							res.send_count = CNT_CMD;
							res.send_bytes = SEND_INIT;
						end else if (short_done && cfg.work_mode == MODE_AUTO) begin
							res.send_count = CNT_CMD;
							res.send_bytes = SEND_MEAS;
						end
					end
					PH_WORK: begin
						if (pending_q) begin
							if (meas_done) begin
								res.read_done  = 1'b1;
								res.data_valid = !busy;
							end
						end else if (cfg.work_mode == MODE_AUTO && period_done) begin
							res.send_count = CNT_CMD;
							res.send_bytes = SEND_MEAS;
						end
					end
					default: begin
						res.send_count = CNT_NONE;
					end
				endcase
			end
			default: begin
				res.send_count = CNT_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_WAKE;
			pending_q <= 1'b0;
			elapsed_q <= '0;
		end else if (fire) begin
			phase_q   <= phase_n;
			pending_q <= pending_n;
			elapsed_q <= elapsed_n;
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/hss_checker.sv
`default_nettype none
module hss_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [1:0]                  send_count,
	input wire logic [hss_pkg::SEND_W-1:0]  send_bytes,
	input wire logic                        read_done,
	input wire logic                        data_valid,
	input wire logic signed [hss_pkg::TEMP_W-1:0] temperature_centi,
	input wire logic [hss_pkg::HUM_W-1:0]   humidity_centi
);
	import hss_pkg::*;

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped under stall");

	// command bytes match the byte count
	a_send: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (send_count == CNT_NONE && send_bytes == SEND_NONE) ||
			(send_count == CNT_RESET && send_bytes == SEND_RESET) ||
			(send_count == CNT_CMD && (send_bytes == SEND_INIT || send_bytes == SEND_MEAS)))
		else $error("command bytes inconsistent with count");

	// readings only come with a read and are zero otherwise
	a_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !data_valid |-> temperature_centi == '0 && humidity_centi == '0)
		else $error("readings without valid data");

	a_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && data_valid |-> read_done && send_count == CNT_NONE &&
			humidity_centi <= HUM_W'(9999) &&
			temperature_centi >= -TEMP_W'(5000))
		else $error("valid data outside a read or out of range");
endmodule

bind humidity_sensor_sequencer_unit hss_checker u_hss_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (results.valid),
	.out_ready        (results.ready),
	.send_count       (results.send_count),
	.send_bytes       (results.send_bytes),
	.read_done        (results.read_done),
	.data_valid       (results.data_valid),
	.temperature_centi(results.temperature_centi),
	.humidity_centi   (results.humidity_centi)
);
`default_nettype wire

// File: test/hss_checker.sv
`timescale 1ns / 1ps
module tb_checker
	import hss_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic                cfg_index,
	input  wire logic [PERIOD_W-1:0] cfg_data,
	hss_in_if                        events,
	hss_out_if                       reports,
	output int                       fail_count,
	output int                       in_flight
);

	typedef struct packed {
		logic [1:0]               cnt;
		logic [SEND_W-1:0]        bytes;
		logic                     rdone;
		logic                     dval;
		logic signed [TEMP_W-1:0] temp;
		logic [HUM_W-1:0]         hum;
	} reading_t;

	reading_t            due_readings[$];
	reading_t            want;
	logic                mode;
	logic [PERIOD_W-1:0] period;
	phase_t              ph;
	logic                waiting;
	logic [31:0]         elapsed;
	int                  fails = 0;

	function automatic reading_t step_sequencer(input logic [1:0] cmd,
		input logic [TICK_W-1:0] tick, input logic [READ_W-1:0] rd);
		reading_t    r;
		logic [32:0] sum;
		logic [31:0] per;
		logic [63:0] q;
		logic [63:0] fl;
		r = '0;
		per = (32'(period) < 32'(MEAS_MS)) ? 32'(MEAS_MS) : 32'(period);
		case (cmd)
			CMD_TICK: begin
				sum = {1'b0, elapsed} + 33'(tick);
				elapsed = sum[32] ? '1 : sum[31:0];
			end
			CMD_REQ: begin
				if (mode == MODE_MANUAL && !waiting) begin
					r.cnt = CNT_CMD;
					r.bytes = SEND_MEAS;
					elapsed = '0;
					waiting = 1'b1;
				end
			end
			CMD_RESTART: begin
				waiting = 1'b0;
				elapsed = '0;
				ph = PH_RESET;
			end
			CMD_RUN: begin
				case (ph)
					PH_WAKE: begin
						if (waiting) begin
							if (elapsed >= 32'(WAIT_SHORT_MS)) begin
								waiting = 1'b0;
								ph = PH_RESET;
							end
						end else begin
							elapsed = '0;
							waiting = 1'b1;
						end
					end
					PH_RESET: begin
						if (waiting) begin
							if (elapsed >= 32'(WAIT_SHORT_MS)) begin
								waiting = 1'b0;
								ph = PH_INIT;
							end
						end else begin
							r.cnt = CNT_RESET;
							r.bytes = SEND_RESET;
							elapsed = '0;
							waiting = 1'b1;
						end
					end
					PH_INIT: begin
						if (waiting) begin
							if (elapsed >= 32'(WAIT_SHORT_MS)) begin
								waiting = 1'b0;
								if (mode == MODE_AUTO) begin
									r.cnt = CNT_CMD;
									r.bytes = SEND_MEAS;
									elapsed = '0;
									waiting = 1'b1;
								end
								ph = PH_WORK;
							end
						end else begin
							r.cnt = CNT_CMD;
							r.bytes = SEND_INIT;
							elapsed = '0;
							waiting = 1'b1;
						end
					end
					PH_WORK: begin
						if (waiting) begin
							if (elapsed >= 32'(MEAS_MS)) begin
								r.rdone = 1'b1;
								if (!rd[STATUS_BIT]) begin
									r.dval = 1'b1;
									q = 64'(rd[RAW_W-1:0]) * 64'(TEMP_SCALE);
									fl = q >> RAW_W;
									// truncate toward zero on both sides of the offset
									if (fl >= 64'(TEMP_OFFSET))
										r.temp = TEMP_W'(fl - 64'(TEMP_OFFSET));
									else
										r.temp = TEMP_W'(((q + 64'd1048575) >> RAW_W)
											- 64'(TEMP_OFFSET));
									r.hum = HUM_W'((64'(rd[2*RAW_W-1:RAW_W])
										* 64'(HUM_SCALE)) >> RAW_W);
								end
								waiting = 1'b0;
							end
						end else if (mode == MODE_AUTO && elapsed >= per) begin
							r.cnt = CNT_CMD;
							r.bytes = SEND_MEAS;
							elapsed = '0;
							waiting = 1'b1;
						end
					end
				endcase
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode = MODE_MANUAL;
			period = PERIOD_RESET;
			ph = PH_WAKE;
			waiting = 1'b0;
			elapsed = '0;
			due_readings.delete();
			in_flight <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_IDX_MODE)
					mode = cfg_data[0];
				else
					period = cfg_data;
			end
			if (reports.valid && reports.ready) begin
				if (due_readings.size() == 0) begin
					fails++;
					$display("%0t result transfer with nothing expected", $time);
				end else begin
					want = due_readings.pop_front();
					if (reports.send_count != want.cnt) begin
						fails++;
						$display("%0t send_count expected %0d actual %0d", $time,
							want.cnt, reports.send_count);
					end
					if (reports.send_bytes != want.bytes) begin
						fails++;
						$display("%0t send_bytes expected %h actual %h", $time,
							want.bytes, reports.send_bytes);
					end
					if (reports.read_done != want.rdone) begin
						fails++;
						$display("%0t read_done expected %0d actual %0d", $time,
							want.rdone, reports.read_done);
					end
					if (reports.data_valid != want.dval) begin
						fails++;
						$display("%0t data_valid expected %0d actual %0d", $time,
							want.dval, reports.data_valid);
					end
					if (reports.temperature_centi != want.temp) begin
						fails++;
						$display("%0t temperature_centi expected %0d actual %0d", $time,
							want.temp, reports.temperature_centi);
					end
					if (reports.humidity_centi != want.hum) begin
						fails++;
						$display("%0t humidity_centi expected %0d actual %0d", $time,
							want.hum, reports.humidity_centi);
					end
				end
			end
			if (events.valid && events.ready)
				due_readings.push_back(step_sequencer(events.cmd, events.tick_ms,
					events.read_data));
			in_flight <= due_readings.size();
		end
		fail_count <= fails;
	end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import hss_pkg::*;

	localparam int STALL_LIMIT      = 5000;
	localparam int RANDOM_PER_PHASE = 140;
	localparam int LONG_TICKS       = 4;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic                cfg_index;
	logic [PERIOD_W-1:0] cfg_data;
	int                  send_idle_pct = 0;
	int                  recv_idle_pct = 0;
	int                  fail_count;
	int                  in_flight;
	int                  quiet_cycles;

	hss_in_if  event_ch();
	hss_out_if report_ch();

	humidity_sensor_sequencer_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.items     (event_ch),
		.results   (report_ch)
	);

	tb_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.events     (event_ch),
		.reports    (report_ch),
		.fail_count (fail_count),
		.in_flight  (in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		report_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			report_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((event_ch.valid && event_ch.ready) || (report_ch.valid && report_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic post_event(input logic [1:0] cmd, input logic [TICK_W-1:0] tick,
		input logic [READ_W-1:0] rd);
		int gap;
		gap = 0;
		if ($urandom_range(99) < send_idle_pct)
			gap = int'($urandom_range(3, 1));
		if (gap > 0) begin
			event_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		event_ch.valid <= 1'b1;
		event_ch.cmd <= cmd;
		event_ch.tick_ms <= tick;
		event_ch.read_data <= rd;
		@(posedge clk);
		while (!event_ch.ready) @(posedge clk);
	endtask

	task automatic settle();
		event_ch.valid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_config(input logic mode, input logic [PERIOD_W-1:0] period);
		cfg_we <= 1'b1;
		cfg_index <= CFG_IDX_MODE;
		cfg_data <= PERIOD_W'(mode);
		@(posedge clk);
		cfg_index <= CFG_IDX_PERIOD;
		cfg_data <= period;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [READ_W-1:0] rand_read();
		return READ_W'({$urandom, $urandom});
	endfunction

	task automatic random_phase(input int send_pct, input int recv_pct, input logic mode,
		input logic [PERIOD_W-1:0] period);
		int          pick;
		logic [1:0]  cmd;
		logic [15:0] tick;
		settle();
		load_config(mode, period);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (RANDOM_PER_PHASE) begin
			pick = int'($urandom_range(99));
			// mostly polls and short ticks so bring-up and measurements complete
			if (pick < 40)
				cmd = CMD_TICK;
			else if (pick < 82)
				cmd = CMD_RUN;
			else if (pick < 95)
				cmd = CMD_REQ;
			else
				cmd = CMD_RESTART;
			if (cmd == CMD_TICK && $urandom_range(99) < 85)
				tick = 16'($urandom_range(120));
			else
				tick = 16'($urandom);
			post_event(cmd, tick, rand_read());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_IDX_MODE;
		cfg_data <= '0;
		event_ch.valid <= 1'b0;
		event_ch.cmd <= CMD_TICK;
		event_ch.tick_ms <= '0;
		event_ch.read_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		load_config(MODE_MANUAL, PERIOD_RESET);

		// bring-up with zero tick and short waits
		post_event(CMD_RUN, 16'($urandom), rand_read());
		post_event(CMD_TICK, '0, rand_read());
		post_event(CMD_RUN, '0, rand_read());
		post_event(CMD_TICK, 16'(WAIT_SHORT_MS), rand_read());
		post_event(CMD_RUN, '0, rand_read());
		post_event(CMD_RUN, '0, rand_read());
		post_event(CMD_TICK, '1, rand_read());
		post_event(CMD_RUN, '0, rand_read());
		post_event(CMD_RUN, '0, rand_read());
		post_event(CMD_TICK, 16'd30, rand_read());
		post_event(CMD_RUN, '0, rand_read());
		// manual measurements: busy, all zero, full scale
		post_event(CMD_REQ, '0, rand_read());
		post_event(CMD_REQ, '0, rand_read());
		post_event(CMD_TICK, 16'(MEAS_MS), rand_read());
		post_event(CMD_RUN, '0, {1'b1, 47'(rand_read())});
		post_event(CMD_REQ, '0, rand_read());
		post_event(CMD_TICK, 16'(MEAS_MS), rand_read());
		post_event(CMD_RUN, '0, '0);
		post_event(CMD_REQ, '0, rand_read());
		post_event(CMD_TICK, 16'd100, rand_read());
		post_event(CMD_RUN, '0, 48'h7FFF_FFFF_FFFF);
		// sequence reset then request outside the working phase
		post_event(CMD_RESTART, 16'($urandom), rand_read());
		post_event(CMD_REQ, '0, rand_read());
		post_event(CMD_TICK, 16'(MEAS_MS), rand_read());
		post_event(CMD_RUN, '0, rand_read());

		// long ticks under the longest period
		settle();
		load_config(MODE_AUTO, '1);
		post_event(CMD_RUN, '0, rand_read());
		post_event(CMD_RUN, '0, rand_read());
		repeat (LONG_TICKS) post_event(CMD_TICK, '1, rand_read());
		post_event(CMD_RUN, '0, rand_read());
		post_event(CMD_TICK, 16'(MEAS_MS), rand_read());
		post_event(CMD_RUN, '0, rand_read());

		random_phase(8, 59, MODE_MANUAL, PERIOD_W'($urandom));
		random_phase(59, 8, MODE_AUTO, '0);
		random_phase(0, 0, MODE_AUTO, PERIOD_W'($urandom_range(400, 80)));
		settle();

		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/hss_pkg.sv
hw/rtl/hss_if.sv
hw/rtl/hss_conv.sv
hw/rtl/hss_ctrl.sv
hw/rtl/humidity_sensor_sequencer_unit.sv
hw/rtl/hss_checker.sv
test/hss_checker.sv
test/tb_top.sv
